[rtl/core/assert_macros.svh]
// ============================================================================
// Assertion macros
// Shared forms for the concurrent checks of the segment tree block.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/strs_pkg.sv]
// ============================================================================
// Segment tree range sum package
// Widths, codes and shared types of the segment tree block.
// ============================================================================
package strs_pkg;

    localparam int CNT_W  = 11;
    localparam int POS_W  = 10;
    localparam int DATA_W = 32;
    localparam int K_W    = CNT_W + 3;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int DEF_NODE_COUNT   = 4096;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1024);

    localparam logic REG_ACTIVE_COUNT = 1'b0;

    localparam logic FUNC_QUERY  = 1'b0;
    localparam logic FUNC_ASSIGN = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic             leaf;
        logic             at_target;
        logic             go_left;
        logic [CNT_W-1:0] mid;
        logic [CNT_W-1:0] mid_p1;
        logic [K_W-1:0]   left_k;
        logic [K_W-1:0]   right_k;
    } t_walk_step;

endpackage

[rtl/core/strs_ram.sv]
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module strs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/strs_alu.sv]
// ============================================================================
// Shared adder
// The single 32-bit add and subtract unit shared by the assign and query sequences.
// ============================================================================
module strs_alu (
    input  logic [strs_pkg::DATA_W-1:0] i_a,
    input  logic [strs_pkg::DATA_W-1:0] i_b,
    input  logic                        i_sub,
    output logic [strs_pkg::DATA_W-1:0] o_y
);

    import strs_pkg::*;

    assign o_y = i_sub ? (i_a - i_b) : (i_a + i_b);

endmodule

[rtl/core/strs_walk.sv]
// ============================================================================
// Tree walk step
// Splits the current node range at its midpoint and gives the child nodes.
// ============================================================================
module strs_walk (
    input  logic [strs_pkg::CNT_W-1:0] i_lo,
    input  logic [strs_pkg::CNT_W-1:0] i_hi,
    input  logic [strs_pkg::CNT_W-1:0] i_target,
    input  logic [strs_pkg::K_W-1:0]   i_k,
    output strs_pkg::t_walk_step       o_step
);

    import strs_pkg::*;

    logic [CNT_W:0]   w_sum;
    logic [CNT_W-1:0] w_mid;
    logic [K_W-1:0]   w_k2;

    assign w_sum = {1'b0, i_lo} + {1'b0, i_hi};
    assign w_mid = w_sum[CNT_W:1];
    assign w_k2  = {i_k[K_W-2:0], 1'b0};

    always_comb begin
        o_step.leaf      = (i_lo == i_hi);
        o_step.at_target = (i_hi == i_target);
        o_step.go_left   = (i_target <= w_mid);
        o_step.mid       = w_mid;
        o_step.mid_p1    = w_mid + CNT_W'(1);
        o_step.left_k    = w_k2 + K_W'(1);
        o_step.right_k   = w_k2 + K_W'(2);
    end

endmodule

[rtl/core/segment_tree_range_sum.sv]
// ============================================================================
// Segment tree range sum
// Point-assign, range-sum segment tree over up to 1024 signed 32-bit elements,
// with midpoint splits of 0..count-1. One item is worked at a time and the
// input stalls meanwhile. Assigns and queries walk the tree from the root
// through the node RAM, whose read data is registered. After reset a clearing
// pass over max(NODE_COUNT, MAX_ELEMENTS) addresses (4096 by default) zeroes
// both stores; no item is taken during it. Out-of-range items return status 1
// with a zero sum.
// ============================================================================
module segment_tree_range_sum #(
    parameter int MAX_ELEMENTS = strs_pkg::DEF_MAX_ELEMENTS,
    parameter int NODE_COUNT   = strs_pkg::DEF_NODE_COUNT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_func,
    input  logic [strs_pkg::POS_W-1:0]         i_position,
    input  logic signed [strs_pkg::DATA_W-1:0] i_new_value,
    input  logic [strs_pkg::POS_W-1:0]         i_range_left,
    input  logic [strs_pkg::POS_W-1:0]         i_range_right,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [strs_pkg::DATA_W-1:0] o_range_sum,
    output logic                               o_status,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [strs_pkg::APB_AW-1:0]        paddr,
    input  logic [strs_pkg::APB_DW-1:0]        pwdata,
    output logic [strs_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);

    import strs_pkg::*;

    localparam int EL_AW     = $clog2(MAX_ELEMENTS);
    localparam int NODE_AW   = $clog2(NODE_COUNT);
    localparam int CLR_DEPTH = (NODE_COUNT > MAX_ELEMENTS) ? NODE_COUNT : MAX_ELEMENTS;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam logic [31:0] NODE_LIM = 32'(NODE_COUNT);
    localparam logic [31:0] EL_LIM   = 32'(MAX_ELEMENTS);
    localparam logic [31:0] CLR_LAST = 32'(CLR_DEPTH - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_RDEL,
        S_A_DELTA,
        S_A_RD,
        S_A_WR,
        S_Q_STEP,
        S_Q_ADD,
        S_Q_LAST,
        S_Q_FIN,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CLR_W-1:0]  r_clr, n_clr;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_sum, n_out_sum;
    logic              r_out_status, n_out_status;
    logic              r_pass, n_pass;
    logic              r_rd_ok, n_rd_ok;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_left, n_left;
    logic [DATA_W-1:0] r_val, n_val;
    logic [CNT_W-1:0]  r_lo, n_lo;
    logic [CNT_W-1:0]  r_hi, n_hi;
    logic [CNT_W-1:0]  r_target, n_target;
    logic [K_W-1:0]    r_k, n_k;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic [DATA_W-1:0] r_sum1, n_sum1;
    logic [DATA_W-1:0] r_res_sum, n_res_sum;
    logic              r_res_status, n_res_status;

    logic [CNT_W-1:0]   w_n_eff;
    logic [CNT_W-1:0]   w_n_last;
    logic               w_in_accept;
    logic               w_cfg_wr;
    logic [CNT_W-1:0]   w_pos_w;
    logic [CNT_W-1:0]   w_right_w;
    logic [DATA_W-1:0]  w_rd;
    t_walk_step         w_step;

    logic               el_we;
    logic [EL_AW-1:0]   el_waddr;
    logic [DATA_W-1:0]  el_wdata;
    logic [EL_AW-1:0]   el_raddr;
    logic [DATA_W-1:0]  el_rdata;
    logic               node_we;
    logic [NODE_AW-1:0] node_waddr;
    logic [DATA_W-1:0]  node_wdata;
    logic [NODE_AW-1:0] node_raddr;
    logic [DATA_W-1:0]  node_rdata;
    logic [DATA_W-1:0]  alu_a;
    logic [DATA_W-1:0]  alu_b;
    logic               alu_sub;
    logic [DATA_W-1:0]  alu_y;

    strs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (el_we),
        .i_waddr (el_waddr),
        .i_wdata (el_wdata),
        .i_raddr (el_raddr),
        .o_rdata (el_rdata)
    );

    strs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    strs_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_y   (alu_y)
    );

    strs_walk u_walk (
        .i_lo     (r_lo),
        .i_hi     (r_hi),
        .i_target (r_target),
        .i_k      (r_k),
        .o_step   (w_step)
    );

    always_comb begin
        if (r_count == '0) begin
            w_n_eff = CNT_W'(1);
        end else if (32'(r_count) > EL_LIM) begin
            w_n_eff = CNT_W'(MAX_ELEMENTS);
        end else begin
            w_n_eff = r_count;
        end
    end

    assign w_n_last    = w_n_eff - CNT_W'(1);
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_cfg_wr    = psel && penable && pwrite && pready
                         && (paddr[APB_AW-1] == REG_ACTIVE_COUNT);
    assign w_pos_w     = CNT_W'(i_position);
    assign w_right_w   = CNT_W'(i_range_right);
    assign w_rd        = r_rd_ok ? node_rdata : '0;

    assign pready      = 1'b1;
    assign prdata      = (paddr[APB_AW-1] == REG_ACTIVE_COUNT) ? APB_DW'(r_count) : '0;
    assign o_out_valid = r_out_valid;
    assign o_range_sum = r_out_sum;
    assign o_status    = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_count      = w_cfg_wr ? pwdata[CNT_W-1:0] : r_count;
        n_clr        = r_clr;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_sum    = r_out_sum;
        n_out_status = r_out_status;
        n_pass       = r_pass;
        n_rd_ok      = r_rd_ok;
        n_pos        = r_pos;
        n_left       = r_left;
        n_val        = r_val;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_target     = r_target;
        n_k          = r_k;
        n_acc        = r_acc;
        n_sum1       = r_sum1;
        n_res_sum    = r_res_sum;
        n_res_status = r_res_status;

        el_we      = 1'b0;
        el_waddr   = EL_AW'(r_pos);
        el_wdata   = r_val;
        el_raddr   = EL_AW'(r_pos);
        node_we    = 1'b0;
        node_waddr = NODE_AW'(r_k);
        node_wdata = alu_y;
        node_raddr = NODE_AW'(r_k);
        alu_a      = r_acc;
        alu_b      = w_rd;
        alu_sub    = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                el_we      = (32'(r_clr) < EL_LIM);
                el_waddr   = EL_AW'(r_clr);
                el_wdata   = '0;
                node_we    = (32'(r_clr) < NODE_LIM);
                node_waddr = NODE_AW'(r_clr);
                node_wdata = '0;
                if (32'(r_clr) == CLR_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + CLR_W'(1);
                end
            end
            S_IDLE: begin
                if (w_in_accept) begin
                    n_pos     = i_position;
                    n_left    = i_range_left;
                    n_val     = i_new_value;
                    n_lo      = '0;
                    n_hi      = w_n_last;
                    n_k       = '0;
                    n_acc     = '0;
                    n_pass    = 1'b0;
                    n_res_sum = '0;
                    unique case (i_func)
                        FUNC_ASSIGN: begin
                            n_target = w_pos_w;
                            if (w_pos_w >= w_n_eff) begin
                                n_res_status = STATUS_ERR;
                                n_state      = S_DONE;
                            end else begin
                                n_res_status = STATUS_OK;
                                n_state      = S_A_RDEL;
                            end
                        end
                        FUNC_QUERY: begin
                            n_target = w_right_w;
                            if (w_right_w >= w_n_eff || i_range_left > i_range_right) begin
                                n_res_status = STATUS_ERR;
                                n_state      = S_DONE;
                            end else begin
                                n_res_status = STATUS_OK;
                                n_state      = S_Q_STEP;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_A_RDEL: begin
                n_state = S_A_DELTA;
            end
            S_A_DELTA: begin
                alu_a   = r_val;
                alu_b   = el_rdata;
                alu_sub = 1'b1;
                n_acc   = alu_y;
                el_we   = 1'b1;
                n_state = S_A_RD;
            end
            S_A_RD: begin
                n_rd_ok = (32'(r_k) < NODE_LIM);
                n_state = S_A_WR;
            end
            S_A_WR: begin
                alu_a   = w_rd;
                alu_b   = r_acc;
                node_we = r_rd_ok;
                if (w_step.leaf) begin
                    n_state = S_DONE;
                end else if (w_step.go_left) begin
                    n_hi    = w_step.mid;
                    n_k     = w_step.left_k;
                    n_state = S_A_RD;
                end else begin
                    n_lo    = w_step.mid_p1;
                    n_k     = w_step.right_k;
                    n_state = S_A_RD;
                end
            end
            S_Q_STEP: begin
                if (w_step.at_target) begin
                    n_rd_ok = (32'(r_k) < NODE_LIM);
                    n_state = S_Q_LAST;
                end else if (w_step.go_left) begin
                    n_hi = w_step.mid;
                    n_k  = w_step.left_k;
                end else begin
                    node_raddr = NODE_AW'(w_step.left_k);
                    n_rd_ok    = (32'(w_step.left_k) < NODE_LIM);
                    n_lo       = w_step.mid_p1;
                    n_k        = w_step.right_k;
                    n_state    = S_Q_ADD;
                end
            end
            S_Q_ADD: begin
                n_acc   = alu_y;
                n_state = S_Q_STEP;
            end
            S_Q_LAST: begin
                if (!r_pass && r_left != '0) begin
                    n_sum1   = alu_y;
                    n_pass   = 1'b1;
                    n_target = CNT_W'(r_left) - CNT_W'(1);
                    n_lo     = '0;
                    n_hi     = w_n_last;
                    n_k      = '0;
                    n_acc    = '0;
                    n_state  = S_Q_STEP;
                end else if (!r_pass) begin
                    n_res_sum = alu_y;
                    n_state   = S_DONE;
                end else begin
                    n_acc   = alu_y;
                    n_state = S_Q_FIN;
                end
            end
            S_Q_FIN: begin
                alu_a     = r_sum1;
                alu_b     = r_acc;
                alu_sub   = 1'b1;
                n_res_sum = alu_y;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_sum    = r_res_sum;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_left       <= n_left;
        r_val        <= n_val;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_target     <= n_target;
        r_k          <= n_k;
        r_acc        <= n_acc;
        r_sum1       <= n_sum1;
        r_res_sum    <= n_res_sum;
        r_res_status <= n_res_status;
        r_out_sum    <= n_out_sum;
        r_out_status <= n_out_status;
        r_rd_ok      <= n_rd_ok;
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_count     <= COUNT_RESET;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_pass      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_pass      <= n_pass;
        end
    end

endmodule

[rtl/core/strs_checker.sv]
// ============================================================================
// Segment tree range sum checker
// Port-level checks on the result channel, the input handshake and the
// configuration register.
// ============================================================================
`include "assert_macros.svh"

module strs_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic signed [strs_pkg::DATA_W-1:0] o_range_sum,
    input logic                               o_status,
    input logic                               psel,
    input logic                               penable,
    input logic                               pwrite,
    input logic [strs_pkg::APB_AW-1:0]        paddr,
    input logic [strs_pkg::APB_DW-1:0]        pwdata,
    input logic [strs_pkg::APB_DW-1:0]        prdata,
    input logic                               pready
);

    import strs_pkg::*;

    logic signed [DATA_W-1:0] r_prev_sum;
    logic                     r_prev_status;
    logic [CNT_W-1:0]         r_prev_wdata;

    logic w_in_beat;
    logic w_out_hold;
    logic w_out_same;
    logic w_err_beat;
    logic w_sum_zero;
    logic w_cfg_wr;
    logic w_rd_count;
    logic w_rd_match;

    always_ff @(posedge i_clk) begin
        r_prev_sum    <= o_range_sum;
        r_prev_status <= o_status;
        r_prev_wdata  <= pwdata[CNT_W-1:0];
    end

    assign w_in_beat  = i_in_valid && !o_in_stall;
    assign w_out_hold = o_out_valid && i_out_stall;
    assign w_out_same = o_out_valid && (o_range_sum == r_prev_sum)
                        && (o_status == r_prev_status);
    assign w_err_beat = o_out_valid && (o_status == STATUS_ERR);
    assign w_sum_zero = (o_range_sum == '0);
    assign w_cfg_wr   = psel && penable && pwrite && pready
                        && (paddr[APB_AW-1] == REG_ACTIVE_COUNT);
    assign w_rd_count = (paddr[APB_AW-1] == REG_ACTIVE_COUNT);
    assign w_rd_match = !w_rd_count || (prdata[CNT_W-1:0] == r_prev_wdata);

    `STRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_hold, w_out_same, "result beat dropped")
    `STRS_ASSERT_NEXT(a_busy, i_clk, i_rst_n, w_in_beat, o_in_stall, "second beat taken early")
    `STRS_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, w_err_beat, w_sum_zero, "error with nonzero sum")
    `STRS_ASSERT_NEXT(a_cfg_rd, i_clk, i_rst_n, w_cfg_wr, w_rd_match, "count readback wrong")

endmodule

bind segment_tree_range_sum strs_checker u_strs_checker (.*);

[tb/sv/segment_tree_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// Segment tree range sum checker
// Watches the item, result and register channels of the segment tree block,
// keeps its own copy of the element and node stores, predicts the sum and
// status of every accepted item and compares them with the results in order.
// ============================================================================
module segment_tree_checker
    import strs_pkg::*;
#(
    parameter int                MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int                NODE_COUNT   = DEF_NODE_COUNT,
    parameter logic [APB_AW-1:0] CFG_ADDR     = '0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic                      i_func,
    input  logic [POS_W-1:0]          i_position,
    input  logic signed [DATA_W-1:0]  i_new_value,
    input  logic [POS_W-1:0]          i_range_left,
    input  logic [POS_W-1:0]          i_range_right,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic signed [DATA_W-1:0]  i_range_sum,
    input  logic                      i_status,
    input  logic                      i_psel,
    input  logic                      i_penable,
    input  logic                      i_pwrite,
    input  logic [APB_AW-1:0]         i_paddr,
    input  logic [APB_DW-1:0]         i_pwdata,
    input  logic                      i_pready,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_result_count,
    output int                        o_error_count
);

    typedef struct packed {
        logic signed [DATA_W-1:0] range_sum;
        logic                     status;
    } t_tree_result;

    logic [DATA_W-1:0] elem_mem [MAX_ELEMENTS];
    logic [DATA_W-1:0] node_mem [NODE_COUNT];
    logic [CNT_W-1:0]  count_cfg;
    t_tree_result      sums_due [$];

    function automatic int unsigned live_count();
        int unsigned n;
        n = 32'(count_cfg);
        if (n == 0) begin
            n = 1;
        end
        if (n > MAX_ELEMENTS) begin
            n = MAX_ELEMENTS;
        end
        return n;
    endfunction

    function automatic logic [DATA_W-1:0] node_at(input int unsigned k);
        return (k < NODE_COUNT) ? node_mem[k] : '0;
    endfunction

    function automatic void node_bump(input int unsigned k, input logic [DATA_W-1:0] delta);
        if (k < NODE_COUNT) begin
            node_mem[k] = node_mem[k] + delta;
        end
    endfunction

    function automatic void bump_path(input int unsigned n, input int unsigned pos,
                                      input logic [DATA_W-1:0] delta);
        int unsigned lo, hi, k, mid;
        lo = 0;
        hi = n - 1;
        k  = 0;
        node_bump(k, delta);
        while (lo != hi) begin
            mid = (lo + hi) / 2;
            if (pos <= mid) begin
                hi = mid;
                k  = 2 * k + 1;
            end else begin
                lo = mid + 1;
                k  = 2 * k + 2;
            end
            node_bump(k, delta);
        end
    endfunction

    function automatic logic [DATA_W-1:0] prefix_sum(input int unsigned n,
                                                     input int unsigned last);
        int unsigned lo, hi, k, mid;
        logic [DATA_W-1:0] acc;
        lo  = 0;
        hi  = n - 1;
        k   = 0;
        acc = '0;
        while (hi != last) begin
            mid = (lo + hi) / 2;
            if (last <= mid) begin
                hi = mid;
                k  = 2 * k + 1;
            end else begin
                acc = acc + node_at(2 * k + 1);
                lo  = mid + 1;
                k   = 2 * k + 2;
            end
        end
        return acc + node_at(k);
    endfunction

    function automatic t_tree_result apply_tree_op(input logic f,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [DATA_W-1:0] val,
                                                   input logic [POS_W-1:0] lft,
                                                   input logic [POS_W-1:0] rgt);
        t_tree_result res;
        int unsigned  n;
        n = live_count();
        res.range_sum = '0;
        res.status    = STATUS_OK;
        if (f == FUNC_ASSIGN) begin
            if (pos >= n) begin
                res.status = STATUS_ERR;
            end else begin
                bump_path(n, pos, val - elem_mem[pos]);
                elem_mem[pos] = val;
            end
        end else if (rgt >= n || lft > rgt) begin
            res.status = STATUS_ERR;
        end else begin
            res.range_sum = prefix_sum(n, rgt);
            if (lft != 0) begin
                res.range_sum = res.range_sum - prefix_sum(n, lft - 1);
            end
        end
        return res;
    endfunction

    // Outputs are stable between the falling edge and the next rising edge,
    // so every beat is taken here, at the falling edge before the rising edge that moves it.
    always @(negedge i_clk) begin
        t_tree_result got;
        t_tree_result want;
        if (!i_rst_n) begin
            foreach (elem_mem[i]) begin
                elem_mem[i] = '0;
            end
            foreach (node_mem[i]) begin
                node_mem[i] = '0;
            end
            count_cfg = COUNT_RESET;
            sums_due.delete();
            o_fail_count   = 0;
            o_result_count = 0;
            o_error_count  = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == CFG_ADDR) begin
                count_cfg = i_pwdata[CNT_W-1:0];
            end
            if (i_in_valid && !i_in_stall) begin
                sums_due.push_back(apply_tree_op(i_func, i_position, i_new_value,
                                                 i_range_left, i_range_right));
            end
            if (i_out_valid && !i_out_stall) begin
                got.range_sum = i_range_sum;
                got.status    = i_status;
                o_result_count++;
                if (got.status == STATUS_ERR) begin
                    o_error_count++;
                end
                if (sums_due.size() == 0) begin
                    $display("%0t: result beat with nothing outstanding, sum %0d status %0d",
                             $time, got.range_sum, got.status);
                    o_fail_count++;
                end else begin
                    want = sums_due.pop_front();
                    if (got.range_sum !== want.range_sum) begin
                        $display("%0t: range_sum expected %0d, actual %0d",
                                 $time, want.range_sum, got.range_sum);
                        o_fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, got.status);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = sums_due.size();
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// Segment tree range sum testbench
// Drives directed and random assigns and range queries through the block
// under several element counts and stall patterns; the checker beside the
// block predicts and compares every result.
// ============================================================================
module tb;
    import strs_pkg::*;

    localparam int RESET_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 64;
    localparam int PHASES         = 9;
    localparam int PHASE_ITEMS    = 100;
    localparam logic [APB_AW-1:0] ADDR_ACTIVE_COUNT = APB_AW'(4 * REG_ACTIVE_COUNT);

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_in_valid    = 1'b0;
    logic                      o_in_stall;
    logic                      i_func        = FUNC_QUERY;
    logic [POS_W-1:0]          i_position    = '0;
    logic signed [DATA_W-1:0]  i_new_value   = '0;
    logic [POS_W-1:0]          i_range_left  = '0;
    logic [POS_W-1:0]          i_range_right = '0;
    logic                      o_out_valid;
    logic                      i_out_stall   = 1'b0;
    logic signed [DATA_W-1:0]  o_range_sum;
    logic                      o_status;
    logic                      psel          = 1'b0;
    logic                      penable       = 1'b0;
    logic                      pwrite        = 1'b0;
    logic [APB_AW-1:0]         paddr         = '0;
    logic [APB_DW-1:0]         pwdata        = '0;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;

    int fail_count;
    int pending;
    int result_count;
    int error_count;

    int  sender_idle_pct   = 32;
    int  receiver_idle_pct = 63;
    int  live_elements     = DEF_MAX_ELEMENTS;
    int  assigns_sent      = 0;
    int  queries_sent      = 0;
    int  count_settings    = 0;
    logic moved            = 1'b0;

    always #4 i_clk = ~i_clk;

    segment_tree_range_sum dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_position    (i_position),
        .i_new_value   (i_new_value),
        .i_range_left  (i_range_left),
        .i_range_right (i_range_right),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_range_sum   (o_range_sum),
        .o_status      (o_status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    segment_tree_checker #(
        .CFG_ADDR (ADDR_ACTIVE_COUNT)
    ) sum_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_position     (i_position),
        .i_new_value    (i_new_value),
        .i_range_left   (i_range_left),
        .i_range_right  (i_range_right),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_range_sum    (o_range_sum),
        .i_status       (o_status),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_error_count  (error_count)
    );

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    always @(negedge i_clk) begin
        moved = (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (psel && penable && pready);
    end

    initial begin
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            stuck = moved ? 0 : stuck + 1;
        end
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    task automatic set_idle(input int mode);
        case (mode)
            0: begin
                sender_idle_pct   = 32;
                receiver_idle_pct = 63;
            end
            1: begin
                sender_idle_pct   = 63;
                receiver_idle_pct = 32;
            end
            default: begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
        endcase
    endtask

    task automatic push_item(input logic f, input logic [POS_W-1:0] pos,
                             input logic [DATA_W-1:0] val,
                             input logic [POS_W-1:0] lft, input logic [POS_W-1:0] rgt);
        logic taken;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= f;
        i_position    <= pos;
        i_new_value   <= val;
        i_range_left  <= lft;
        i_range_right <= rgt;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        if (f == FUNC_ASSIGN) begin
            assigns_sent++;
        end else begin
            queries_sent++;
        end
    endtask

    task automatic random_item();
        logic              f;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  lft;
        logic [POS_W-1:0]  rgt;
        logic [POS_W-1:0]  swap;
        logic [DATA_W-1:0] val;
        f   = 1'($urandom_range(1));
        pos = POS_W'($urandom_range(1023));
        lft = POS_W'($urandom_range(1023));
        rgt = POS_W'($urandom_range(1023));
        val = $urandom;
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
                0:       val = 32'h7FFF_FFFF;
                1:       val = 32'h8000_0000;
                2:       val = '0;
                default: val = '1;
            endcase
        end
        if ($urandom_range(99) < 85) begin
            pos = POS_W'($urandom_range(live_elements - 1));
            lft = POS_W'($urandom_range(live_elements - 1));
            rgt = POS_W'($urandom_range(live_elements - 1));
            if (lft > rgt) begin
                swap = lft;
                lft  = rgt;
                rgt  = swap;
            end
            if ($urandom_range(15) == 0) begin
                lft = '0;
                rgt = POS_W'(live_elements - 1);
            end
        end
        push_item(f, pos, val, lft, rgt);
    endtask

    // Waits at a rising edge until every outstanding result has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [APB_DW-1:0] value);
        logic done;
        int   n;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ACTIVE_COUNT;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            done = pready;
            @(posedge i_clk);
        end while (!done);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n = 32'(value[CNT_W-1:0]);
        if (n == 0) begin
            n = 1;
        end
        if (n > DEF_MAX_ELEMENTS) begin
            n = DEF_MAX_ELEMENTS;
        end
        live_elements = n;
        count_settings++;
    endtask

    initial begin
        int phase_count [PHASES];
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_idle(0);

        write_count(32'd1024);
        push_item(FUNC_ASSIGN, 10'd0,    32'h7FFF_FFFF, 10'd0, 10'd0);
        push_item(FUNC_ASSIGN, 10'd1023, 32'h8000_0000, 10'd0, 10'd0);
        push_item(FUNC_ASSIGN, 10'd511,  32'hFFFF_FFFF, 10'd0, 10'd0);
        push_item(FUNC_ASSIGN, 10'd512,  32'd1,         10'd0, 10'd0);
        push_item(FUNC_QUERY,  10'd0, 32'd0, 10'd0,    10'd1023);
        push_item(FUNC_QUERY,  10'd0, 32'd0, 10'd0,    10'd0);
        push_item(FUNC_QUERY,  10'd0, 32'd0, 10'd1023, 10'd1023);
        push_item(FUNC_QUERY,  10'd0, 32'd0, 10'd511,  10'd512);
        push_item(FUNC_QUERY,  10'd0, 32'd0, 10'd1,    10'd1022);
        push_item(FUNC_QUERY,  10'd0, 32'd0, 10'd600,  10'd5);
        push_item(FUNC_ASSIGN, 10'd0, 32'h8000_0000, 10'd0, 10'd0);
        push_item(FUNC_QUERY,  10'd0, 32'd0, 10'd0,    10'd511);
        settle();

        // A count of zero behaves as a single element.
        write_count(32'd0);
        push_item(FUNC_ASSIGN, 10'd0,    32'd12345, 10'd0, 10'd0);
        push_item(FUNC_ASSIGN, 10'd1,    32'd99,    10'd0, 10'd0);
        push_item(FUNC_QUERY,  10'd0,    32'd0,     10'd0, 10'd0);
        push_item(FUNC_QUERY,  10'd0,    32'd0,     10'd0, 10'd1);
        push_item(FUNC_ASSIGN, 10'd1023, 32'd7,     10'd0, 10'd0);
        settle();

        // Above the maximum the count is clamped; the stored nodes are reused.
        write_count(32'd2047);
        push_item(FUNC_QUERY,  10'd0,    32'd0, 10'd0,    10'd0);
        push_item(FUNC_QUERY,  10'd0,    32'd0, 10'd0,    10'd1023);
        push_item(FUNC_ASSIGN, 10'd1023, 32'd7, 10'd0,    10'd0);
        push_item(FUNC_QUERY,  10'd0,    32'd0, 10'd1000, 10'd1023);
        settle();

        // Bits above the register width are dropped, leaving a count of three.
        write_count(32'hFFFF_F803);
        push_item(FUNC_QUERY,  10'd0, 32'd0, 10'd0, 10'd2);
        push_item(FUNC_QUERY,  10'd0, 32'd0, 10'd2, 10'd3);
        push_item(FUNC_ASSIGN, 10'd3, 32'd5, 10'd0, 10'd0);
        push_item(FUNC_ASSIGN, 10'd2, 32'd5, 10'd0, 10'd0);
        push_item(FUNC_QUERY,  10'd0, 32'd0, 10'd1, 10'd2);
        settle();

        phase_count = '{1024, 2, 0, 1, 1023, 2047, 0, 0, 1024};
        phase_count[2] = $urandom_range(3, 1022);
        phase_count[6] = $urandom_range(3, 1022);
        for (int p = 0; p < PHASES; p++) begin
            set_idle(p / 3);
            write_count(phase_count[p]);
            repeat (PHASE_ITEMS) random_item();
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d items (%0d assigns, %0d queries) under %0d count settings",
                 assigns_sent + queries_sent, assigns_sent, queries_sent, count_settings);
        $display("and three stall patterns; compared %0d results, %0d flagged out of range.",
                 result_count, error_count);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
